/* src/ilt_pkg.sv */
package ilt_pkg;

  localparam int MAX_ENTRIES  = 64;
  localparam int WORD_BITS    = 32;
  localparam int POS_BITS     = 6;
  localparam int IN_WORD_BITS = 32;
  localparam int LEN_BITS     = 7;

  typedef enum logic [2:0] {
    CMD_GET    = 3'd0,
    CMD_SET    = 3'd1,
    CMD_INSERT = 3'd2,
    CMD_DELETE = 3'd3,
    CMD_SEARCH = 3'd4,
    CMD_CLEAR  = 3'd5
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_BAD_INDEX = 2'd1,
    ST_FULL      = 2'd2,
    ST_EMPTY     = 2'd3
  } status_e;

  typedef struct packed {
    logic [2:0]                     cmd;
    logic [POS_BITS-1:0]            position;
    logic signed [IN_WORD_BITS-1:0] word_in;
  } ilt_in_t;

  typedef struct packed {
    logic signed [IN_WORD_BITS-1:0] word_out;
    logic                           found;
    logic [LEN_BITS-1:0]            length;
    logic [1:0]                     status;
  } ilt_out_t;

  // per-cycle command broadcast to the cell row, only for checked commands
  typedef struct packed {
    logic do_get;
    logic do_set;
    logic do_ins;
    logic do_del;
    logic do_srch;
  } ilt_ctrl_t;

endpackage

/* src/ilt_cell.sv */
module ilt_cell #(
  parameter int WORD_BITS = ilt_pkg::WORD_BITS,
  parameter int CNT_W     = 7,
  parameter int IDX       = 0
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  ilt_pkg::ilt_ctrl_t          ctrl_i,
  input  logic [ilt_pkg::POS_BITS-1:0] pos_i,
  input  logic [CNT_W-1:0]            count_i,
  input  logic [WORD_BITS-1:0]        word_i,
  input  logic [WORD_BITS-1:0]        left_i,
  input  logic [WORD_BITS-1:0]        right_i,
  output logic [WORD_BITS-1:0]        entry_o,
  output logic [WORD_BITS-1:0]        rd_o,
  output logic                        match_o
);

  localparam int CMP_W = (CNT_W > ilt_pkg::POS_BITS) ? CNT_W : ilt_pkg::POS_BITS;
  localparam logic [CMP_W-1:0] MY_IDX = CMP_W'(IDX);

  logic [WORD_BITS-1:0] entry_q, entry_d;
  logic [WORD_BITS-1:0] rd_q, rd_d;
  logic                 match_q, match_d;
  logic [CMP_W-1:0]     pos_x, cnt_x;
  logic                 here, above, live;

  assign pos_x = CMP_W'(pos_i);
  assign cnt_x = CMP_W'(count_i);
  assign here  = (MY_IDX == pos_x);
  assign above = (MY_IDX > pos_x);
  assign live  = (MY_IDX < cnt_x);

  always_comb begin
    entry_d = entry_q;
    if ((ctrl_i.do_set || ctrl_i.do_ins) && here) begin
      entry_d = word_i;
    end else if (ctrl_i.do_ins && above) begin
      entry_d = left_i;
    end else if (ctrl_i.do_del && (above || here)) begin
      entry_d = right_i;
    end
  end

  // get and search look at contents before this command's update
  assign rd_d    = (ctrl_i.do_get && here) ? entry_q : '0;
  assign match_d = ctrl_i.do_srch && live && (entry_q == word_i);

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
    rd_q    <= rd_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      match_q <= 1'b0;
    end else begin
      match_q <= match_d;
    end
  end

  assign entry_o = entry_q;
  assign rd_o    = rd_q;
  assign match_o = match_q;

endmodule

/* src/indexed_list_table.sv */
// A result strobes on done_o after the accepted command is registered through v1_q and then done_q.
// Throughput: one command per cycle; busy_o stays low, and the receiver cannot stall.
// Insert and delete shift the cells from the given position upward, all at the same edge;
// get and search are gathered from the row through one extra register stage.
// Reset clears the entry count and the pipeline valids; entry contents are not cleared.
module indexed_list_table #(
  parameter int MAX_ENTRIES = ilt_pkg::MAX_ENTRIES,
  parameter int WORD_BITS   = ilt_pkg::WORD_BITS
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  output logic             busy_o,
  input  ilt_pkg::ilt_in_t cmd_i,
  output logic             done_o,
  output ilt_pkg::ilt_out_t res_o
);

  localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
  localparam int CMP_W = (CNT_W > ilt_pkg::POS_BITS) ? CNT_W : ilt_pkg::POS_BITS;
  localparam int LEN_W = ilt_pkg::LEN_BITS;
  localparam int IW    = ilt_pkg::IN_WORD_BITS;

  logic [CNT_W-1:0]     count_q, count_d;
  logic [CMP_W-1:0]     pos_x, cnt_x;
  logic                 accept;
  ilt_pkg::ilt_ctrl_t   ctrl;
  ilt_pkg::status_e     status_d;
  logic [WORD_BITS-1:0] word_w;
  logic [WORD_BITS+IW-1:0] word_ext;
  logic [CNT_W+LEN_W-1:0]  len_ext;

  logic                 v1_q;
  logic [LEN_W-1:0]     len1_q;
  logic [1:0]           st1_q;

  logic [WORD_BITS-1:0] chain_w [0:MAX_ENTRIES+1];
  logic [WORD_BITS-1:0] rd_w    [0:MAX_ENTRIES-1];
  logic [MAX_ENTRIES-1:0] match_w;

  logic [WORD_BITS-1:0]    rd_or;
  logic [IW+WORD_BITS-1:0] out_ext;
  logic                    done_q;
  ilt_pkg::ilt_out_t       res_q, res_d;

  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;
  assign pos_x  = CMP_W'(cmd_i.position);
  assign cnt_x  = CMP_W'(count_q);

  assign word_ext = {WORD_BITS'(0), cmd_i.word_in};
  assign word_w   = word_ext[WORD_BITS-1:0];

  // command check; flagged commands leave cells and count untouched
  always_comb begin
    ctrl     = '0;
    count_d  = count_q;
    status_d = ilt_pkg::ST_OK;
    if (accept) begin
      unique case (cmd_i.cmd)
        ilt_pkg::CMD_GET: begin
          if (pos_x < cnt_x) ctrl.do_get = 1'b1;
          else status_d = ilt_pkg::ST_BAD_INDEX;
        end
        ilt_pkg::CMD_SET: begin
          if (pos_x < cnt_x) ctrl.do_set = 1'b1;
          else status_d = ilt_pkg::ST_BAD_INDEX;
        end
        ilt_pkg::CMD_INSERT: begin
          if (count_q == CNT_W'(MAX_ENTRIES)) begin
            status_d = ilt_pkg::ST_FULL;
          end else if (pos_x > cnt_x) begin
            status_d = ilt_pkg::ST_BAD_INDEX;
          end else begin
            ctrl.do_ins = 1'b1;
            count_d     = count_q + CNT_W'(1);
          end
        end
        ilt_pkg::CMD_DELETE: begin
          if (count_q == '0) begin
            status_d = ilt_pkg::ST_EMPTY;
          end else if (pos_x >= cnt_x) begin
            status_d = ilt_pkg::ST_BAD_INDEX;
          end else begin
            ctrl.do_del = 1'b1;
            count_d     = count_q - CNT_W'(1);
          end
        end
        ilt_pkg::CMD_SEARCH: ctrl.do_srch = 1'b1;
        ilt_pkg::CMD_CLEAR:  count_d = '0;
        default: ;
      endcase
    end
  end

  assign len_ext = {LEN_W'(0), count_d};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      v1_q    <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      count_q <= count_d;
      v1_q    <= accept;
      done_q  <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    len1_q <= len_ext[LEN_W-1:0];
    st1_q  <= status_d;
    res_q  <= res_d;
  end

  // cell row; ends of the chain see zero
  assign chain_w[0]             = '0;
  assign chain_w[MAX_ENTRIES+1] = '0;

  for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
    ilt_cell #(
      .WORD_BITS (WORD_BITS),
      .CNT_W     (CNT_W),
      .IDX       (i)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctrl_i  (ctrl),
      .pos_i   (cmd_i.position),
      .count_i (count_q),
      .word_i  (word_w),
      .left_i  (chain_w[i]),
      .right_i (chain_w[i+2]),
      .entry_o (chain_w[i+1]),
      .rd_o    (rd_w[i]),
      .match_o (match_w[i])
    );
  end

  // at most one cell drives a nonzero read value
  always_comb begin
    rd_or = '0;
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      rd_or = rd_or | rd_w[i];
    end
  end

  assign out_ext = {IW'(0), rd_or};

  always_comb begin
    res_d          = '0;
    res_d.word_out = out_ext[IW-1:0];
    res_d.found    = |match_w;
    res_d.length   = len1_q;
    res_d.status   = st1_q;
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

/* src/ilt_checker.sv */
module ilt_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              start_i,
  input logic              busy_o,
  input ilt_pkg::ilt_in_t  cmd_i,
  input logic              done_o,
  input ilt_pkg::ilt_out_t res_o
);

  logic acc;
  assign acc = start_i && !busy_o;

  a_done_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc |-> ##2 done_o)
    else $error("item accepted without result two cycles later");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(acc, 2))
    else $error("result without accepted item");

  a_fail_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && res_o.status != ilt_pkg::ST_OK) |-> (res_o.word_out == '0 && !res_o.found))
    else $error("flagged item carries data");

  a_found_search: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && res_o.found) |-> $past(cmd_i.cmd == ilt_pkg::CMD_SEARCH, 2))
    else $error("found flag on a non-search item");

endmodule

bind indexed_list_table ilt_checker u_ilt_checker (
  .clk_i   (clk_i),
  .rst_ni  (rst_ni),
  .start_i (start_i),
  .busy_o  (busy_o),
  .cmd_i   (cmd_i),
  .done_o  (done_o),
  .res_o   (res_o)
);

/* dv/indexed_list_table_test.sv */
module indexed_list_table_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CLK_PERIOD  = 10;
  localparam int RST_CYCLES  = 11;
  localparam int RAND_ITEMS  = 1250;
  localparam int DRAIN_WAIT  = 8;
  localparam int CYCLE_LIMIT = 200_000;

  // codes the block must treat as no-ops
  localparam logic [2:0] CMD_SPARE_6 = 3'd6;
  localparam logic [2:0] CMD_SPARE_7 = 3'd7;

  typedef struct {
    ilt_pkg::ilt_in_t  item;
    bit                has_want;
    ilt_pkg::ilt_out_t want;
  } dir_row_t;

  logic              clk_i   = 1'b0;
  logic              rst_ni  = 1'b0;
  logic              start_i = 1'b0;
  ilt_pkg::ilt_in_t  cmd_i   = '0;
  logic              busy_o;
  logic              done_o;
  ilt_pkg::ilt_out_t res_o;

  indexed_list_table uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start_i),
    .busy_o (busy_o),
    .cmd_i  (cmd_i),
    .done_o (done_o),
    .res_o  (res_o)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // shadow copy of the list
  logic [ilt_pkg::WORD_BITS-1:0] list_words [ilt_pkg::MAX_ENTRIES];
  int unsigned                   list_len = 0;

  ilt_pkg::ilt_out_t expected_results [$];
  ilt_pkg::ilt_out_t head_result;
  dir_row_t    dir_rows [$];
  int unsigned errors     = 0;
  int unsigned cycles     = 0;
  int unsigned n_items    = 0;
  int unsigned n_counted  = 0;
  int unsigned n_full     = 0;
  int unsigned n_empty    = 0;
  int unsigned n_bad      = 0;
  int unsigned n_hits     = 0;
  int unsigned n_peak     = 0;
  bit          idle_on    = 1'b1;

  function automatic ilt_pkg::ilt_out_t step_list(input ilt_pkg::ilt_in_t c);
    ilt_pkg::ilt_out_t r;
    int unsigned       p;
    int unsigned       j;
    r = '0;
    r.status = ilt_pkg::ST_OK;
    p = c.position;
    case (c.cmd)
      ilt_pkg::CMD_GET: begin
        if (p < list_len) r.word_out = list_words[p];
        else r.status = ilt_pkg::ST_BAD_INDEX;
      end
      ilt_pkg::CMD_SET: begin
        if (p < list_len) list_words[p] = c.word_in;
        else r.status = ilt_pkg::ST_BAD_INDEX;
      end
      ilt_pkg::CMD_INSERT: begin
        if (list_len >= ilt_pkg::MAX_ENTRIES) begin
          r.status = ilt_pkg::ST_FULL;
        end else if (p > list_len) begin
          r.status = ilt_pkg::ST_BAD_INDEX;
        end else begin
          for (j = list_len; j > p; j--) list_words[j] = list_words[j-1];
          list_words[p] = c.word_in;
          list_len++;
        end
      end
      ilt_pkg::CMD_DELETE: begin
        if (list_len == 0) begin
          r.status = ilt_pkg::ST_EMPTY;
        end else if (p >= list_len) begin
          r.status = ilt_pkg::ST_BAD_INDEX;
        end else begin
          for (j = p; j + 1 < list_len; j++) list_words[j] = list_words[j+1];
          list_len--;
        end
      end
      ilt_pkg::CMD_SEARCH: begin
        for (j = 0; j < list_len; j++) begin
          if (list_words[j] == c.word_in) r.found = 1'b1;
        end
      end
      ilt_pkg::CMD_CLEAR: list_len = 0;
      default: ;
    endcase
    r.length = list_len[ilt_pkg::LEN_BITS-1:0];
    return r;
  endfunction

  // mix of random words, corner values and words already in the list
  function automatic logic [31:0] pick_word();
    int unsigned sel;
    sel = $urandom_range(0, 9);
    if (sel < 4) return $urandom();
    if (sel < 6 && list_len > 0) return list_words[$urandom_range(0, list_len - 1)];
    case ($urandom_range(0, 4))
      0: return 32'h0000_0000;
      1: return 32'hFFFF_FFFF;
      2: return 32'h8000_0000;
      3: return 32'h7FFF_FFFF;
      default: return $urandom_range(0, 15);
    endcase
  endfunction

  function automatic dir_row_t plain(input logic [2:0] c, input int unsigned p,
                                     input logic [31:0] w);
    dir_row_t d;
    d.item = '{cmd: c, position: p[ilt_pkg::POS_BITS-1:0], word_in: w};
    d.has_want = 1'b0;
    d.want = '0;
    return d;
  endfunction

  function automatic dir_row_t checked(input logic [2:0] c, input int unsigned p,
                                       input logic [31:0] w, input logic [31:0] wo,
                                       input bit f, input int unsigned n,
                                       input ilt_pkg::status_e s);
    dir_row_t d;
    d = plain(c, p, w);
    d.has_want = 1'b1;
    d.want = '{word_out: wo, found: f, length: n[ilt_pkg::LEN_BITS-1:0], status: s};
    return d;
  endfunction

  // start stays high from one item to the next unless an idle gap is taken
  task automatic send(input logic [2:0] c, input int unsigned p, input logic [31:0] w,
                      input bit has_want = 1'b0, input ilt_pkg::ilt_out_t want = '0);
    ilt_pkg::ilt_in_t  item;
    ilt_pkg::ilt_out_t r;
    item = '{cmd: c, position: p[ilt_pkg::POS_BITS-1:0], word_in: w};
    if (idle_on) begin
      while ($urandom_range(0, 99) < 37) begin
        start_i <= 1'b0;
        @(posedge clk_i);
      end
    end
    start_i <= 1'b1;
    cmd_i   <= item;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    r = step_list(item);
    expected_results.push_back(has_want ? want : r);
    n_items++;
    if (r.status == ilt_pkg::ST_FULL) n_full++;
    if (r.status == ilt_pkg::ST_EMPTY) n_empty++;
    if (r.status == ilt_pkg::ST_BAD_INDEX) n_bad++;
    if (r.found) n_hits++;
    if (list_len > n_peak) n_peak = list_len;
  endtask

  task automatic send_counted(input logic [2:0] c, input int unsigned p,
                              input logic [31:0] w);
    idle_on = !(n_counted >= 500 && n_counted < 800);
    send(c, p, w);
    if (c != CMD_SPARE_6 && c != CMD_SPARE_7) n_counted++;
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (expected_results.size() == 0) begin
        $error("result with no item pending: %p", res_o);
        errors++;
      end else begin
        head_result = expected_results.pop_front();
        if (res_o.word_out !== head_result.word_out) begin
          $error("word_out: expected %0d, got %0d", head_result.word_out, res_o.word_out);
          errors++;
        end
        if (res_o.found !== head_result.found) begin
          $error("found: expected %0b, got %0b", head_result.found, res_o.found);
          errors++;
        end
        if (res_o.length !== head_result.length) begin
          $error("length: expected %0d, got %0d", head_result.length, res_o.length);
          errors++;
        end
        if (res_o.status !== head_result.status) begin
          $error("status: expected %0d, got %0d", head_result.status, res_o.status);
          errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    logic [2:0]  c;
    int unsigned p;
    int unsigned sel;

    dir_rows.push_back(checked(ilt_pkg::CMD_GET,     0, 32'h0,         32'h0, 0, 0,
                               ilt_pkg::ST_BAD_INDEX));
    dir_rows.push_back(checked(ilt_pkg::CMD_DELETE,  0, 32'h0,         32'h0, 0, 0,
                               ilt_pkg::ST_EMPTY));
    dir_rows.push_back(checked(ilt_pkg::CMD_SEARCH,  0, 32'h0,         32'h0, 0, 0,
                               ilt_pkg::ST_OK));
    dir_rows.push_back(checked(ilt_pkg::CMD_SET,     0, 32'h5,         32'h0, 0, 0,
                               ilt_pkg::ST_BAD_INDEX));
    dir_rows.push_back(checked(ilt_pkg::CMD_INSERT,  1, 32'h9,         32'h0, 0, 0,
                               ilt_pkg::ST_BAD_INDEX));
    dir_rows.push_back(checked(ilt_pkg::CMD_INSERT,  0, 32'h7FFF_FFFF, 32'h0, 0, 1,
                               ilt_pkg::ST_OK));
    dir_rows.push_back(checked(ilt_pkg::CMD_INSERT,  0, 32'h8000_0000, 32'h0, 0, 2,
                               ilt_pkg::ST_OK));
    // position equal to the count appends
    dir_rows.push_back(checked(ilt_pkg::CMD_INSERT,  2, 32'hFFFF_FFFF, 32'h0, 0, 3,
                               ilt_pkg::ST_OK));
    dir_rows.push_back(checked(ilt_pkg::CMD_GET,     0, 32'h0, 32'h8000_0000, 0, 3,
                               ilt_pkg::ST_OK));
    dir_rows.push_back(checked(ilt_pkg::CMD_GET,     2, 32'h0, 32'hFFFF_FFFF, 0, 3,
                               ilt_pkg::ST_OK));
    dir_rows.push_back(checked(ilt_pkg::CMD_GET,    63, 32'h0,         32'h0, 0, 3,
                               ilt_pkg::ST_BAD_INDEX));
    dir_rows.push_back(checked(ilt_pkg::CMD_SEARCH,  0, 32'h7FFF_FFFF, 32'h0, 1, 3,
                               ilt_pkg::ST_OK));
    dir_rows.push_back(plain(ilt_pkg::CMD_SET,       1, 32'h0));
    dir_rows.push_back(plain(ilt_pkg::CMD_SEARCH,    0, 32'h7FFF_FFFF));
    dir_rows.push_back(plain(ilt_pkg::CMD_INSERT,    1, 32'h1234_5678));
    dir_rows.push_back(plain(ilt_pkg::CMD_DELETE,    0, 32'h0));
    dir_rows.push_back(plain(ilt_pkg::CMD_GET,       0, 32'h0));
    dir_rows.push_back(checked(ilt_pkg::CMD_DELETE,  3, 32'h0,         32'h0, 0, 3,
                               ilt_pkg::ST_BAD_INDEX));
    dir_rows.push_back(checked(CMD_SPARE_6,         63, 32'hFFFF_FFFF, 32'h0, 0, 3,
                               ilt_pkg::ST_OK));
    dir_rows.push_back(checked(CMD_SPARE_7,          0, 32'h0,         32'h0, 0, 3,
                               ilt_pkg::ST_OK));
    dir_rows.push_back(plain(ilt_pkg::CMD_DELETE,    2, 32'h0));
    dir_rows.push_back(checked(ilt_pkg::CMD_CLEAR,   0, 32'h0,         32'h0, 0, 0,
                               ilt_pkg::ST_OK));
    // stale words above the count must not match
    dir_rows.push_back(checked(ilt_pkg::CMD_SEARCH,  0, 32'h1234_5678, 32'h0, 0, 0,
                               ilt_pkg::ST_OK));
    dir_rows.push_back(checked(ilt_pkg::CMD_GET,     0, 32'h0,         32'h0, 0, 0,
                               ilt_pkg::ST_BAD_INDEX));

    repeat (RST_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (dir_rows[i]) begin
      send(dir_rows[i].item.cmd, dir_rows[i].item.position, dir_rows[i].item.word_in,
           dir_rows[i].has_want, dir_rows[i].want);
    end

    while (n_counted < RAND_ITEMS) begin
      case ($urandom_range(0, 2))
        0: begin
          // grow to full, then hit the full list
          while (list_len < ilt_pkg::MAX_ENTRIES) begin
            if ($urandom_range(0, 4) == 0) begin
              send_counted(ilt_pkg::CMD_SEARCH, 0, pick_word());
            end else begin
              send_counted(ilt_pkg::CMD_INSERT, $urandom_range(0, list_len), pick_word());
            end
          end
          repeat ($urandom_range(1, 3)) send_counted(ilt_pkg::CMD_INSERT,
                                                     $urandom_range(0, 63), pick_word());
        end
        1: begin
          while (list_len > 0) begin
            if ($urandom_range(0, 4) == 0) begin
              send_counted(ilt_pkg::CMD_GET, $urandom_range(0, list_len - 1), 32'h0);
            end else begin
              send_counted(ilt_pkg::CMD_DELETE, $urandom_range(0, list_len - 1),
                           pick_word());
            end
          end
          repeat ($urandom_range(1, 2)) send_counted(ilt_pkg::CMD_DELETE,
                                                     $urandom_range(0, 63), $urandom());
        end
        default: begin
          repeat ($urandom_range(20, 40)) begin
            sel = $urandom_range(0, 99);
            if (sel < 20)      c = ilt_pkg::CMD_GET;
            else if (sel < 35) c = ilt_pkg::CMD_SET;
            else if (sel < 55) c = ilt_pkg::CMD_INSERT;
            else if (sel < 75) c = ilt_pkg::CMD_DELETE;
            else if (sel < 90) c = ilt_pkg::CMD_SEARCH;
            else if (sel < 93) c = ilt_pkg::CMD_CLEAR;
            else if (sel < 97) c = CMD_SPARE_6;
            else               c = CMD_SPARE_7;
            if (c == ilt_pkg::CMD_INSERT && $urandom_range(0, 3) != 0) begin
              p = $urandom_range(0, list_len);
            end else if (list_len > 0 && $urandom_range(0, 3) != 0) begin
              p = $urandom_range(0, list_len - 1);
            end else begin
              p = $urandom_range(0, 63);
            end
            send_counted(c, p, pick_word());
          end
        end
      endcase
    end

    start_i <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);

    $display("%0d commands sent, list length peaked at %0d", n_items, n_peak);
    $display("%0d full-list, %0d empty-list, %0d bad-index results, %0d search hits",
             n_full, n_empty, n_bad, n_hits);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

/* filelist.f */
src/ilt_pkg.sv
src/ilt_cell.sv
src/indexed_list_table.sv
src/ilt_checker.sv
dv/indexed_list_table_test.sv
